// File: hdl/cau_pkg.sv
// shared types, operation codes and saturation helper of the complex arithmetic unit
`timescale 1ns / 1ps
package cau_pkg;

    // operation codes
    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_MUL  = 3'd1;
    localparam logic [2:0] OP_DIV  = 3'd2;
    localparam logic [2:0] OP_SQ   = 3'd3;
    localparam logic [2:0] OP_BS   = 3'd4;
    localparam logic [2:0] OP_CUBE = 3'd5;

    // word limits
    localparam logic signed [67:0] SAT_MAX = 68'sd2147483647;
    localparam logic signed [67:0] SAT_MIN = -68'sd2147483648;
    localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] WORD_MIN = 32'h8000_0000;

    // input request
    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] a_re;
        logic signed [31:0] a_im;
        logic signed [31:0] b_re;
        logic signed [31:0] b_im;
    } t_req;

    // result request
    typedef struct packed {
        logic signed [31:0] res_re;
        logic signed [31:0] res_im;
        logic [30:0]        modulus_sq;
        logic               overflow;
        logic               div_zero;
    } t_res;

    // decoded operation class, one-hot or all zero for unused codes
    typedef struct packed {
        logic add;
        logic mul;
        logic div;
        logic sq;
        logic bs;
        logic cube;
    } t_cls;

    // classified request from front to back
    typedef struct packed {
        t_cls               cls;
        logic               dz;
        logic signed [31:0] a_re;
        logic signed [31:0] a_im;
        logic signed [31:0] b_re;
        logic signed [31:0] b_im;
    } t_cmd;

    // finished non-divide result carried beside the divider
    typedef struct packed {
        logic               valid;
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic [30:0]        m;
        logic               ov;
        logic               dz;
        logic               div;
    } t_side;

    // one divider stage: both quotients share the divisor
    typedef struct packed {
        t_side       side;
        logic [63:0] den;
        logic [63:0] mag_re;
        logic [63:0] mag_im;
        logic        neg_re;
        logic        neg_im;
        logic [63:0] rem_re;
        logic [63:0] rem_im;
        logic [33:0] q_re;
        logic [33:0] q_im;
        logic        st_re;
        logic        st_im;
    } t_dv;

    // saturate to the word range, msb flags saturation
    function automatic logic [32:0] f_sat(input logic signed [67:0] v);
        logic [32:0] res;
        if (v > SAT_MAX) begin
            res = {1'b1, WORD_MAX};
        end else if (v < SAT_MIN) begin
            res = {1'b1, WORD_MIN};
        end else begin
            res = {1'b0, v[31:0]};
        end
        return res;
    endfunction

endpackage

// File: hdl/complex_arith_unit.sv
// top level of the fixed-point complex arithmetic unit
//
// Usage:
//   Requests enter as a queue: drive i_req and raise i_push; the request is
//   taken at a rising edge with i_push high and o_full low.
//   Results leave as a queue: while o_empty is low the oldest result sits on
//   o_res; it is taken at a rising edge with i_pop high.
//   One result per request, in request order.
// Divider: resolves one dividend bit per stage over 64 + FRAC_BITS stages.
// Throughput: one request per cycle while the result queue has room; every
//   operation takes the same path, and multiplies are 32 by 32 bits with a
//   register after each.
// Reset: synchronous, active low; empties both queues and drops all requests
//   in flight.
// Stall: when the result queue is full the whole back pipeline holds; the
//   four-entry request queue keeps accepting until it fills, then o_full rises.
`timescale 1ns / 1ps
module complex_arith_unit
    import cau_pkg::*;
#(
    parameter int FRAC_BITS = 28
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_req,
    output logic o_full,
    output logic o_empty,
    input  logic i_pop,
    output t_res o_res
);
    t_cmd w_cmd;
    logic w_cmd_empty, w_cmd_pop;

    // request decode and queue
    cau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_req   (i_req),
        .o_full  (o_full),
        .i_pop   (w_cmd_pop),
        .o_cmd   (w_cmd),
        .o_empty (w_cmd_empty)
    );

    // arithmetic pipeline and result queue
    cau_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_empty (w_cmd_empty),
        .o_pop   (w_cmd_pop),
        .o_res   (o_res),
        .o_empty (o_empty),
        .i_pop   (i_pop)
    );

endmodule

// File: hdl/cau_queue.sv
// small register queue with push/full and pop/empty sides
`timescale 1ns / 1ps
module cau_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: hdl/cau_front.sv
// front part: accepts requests, decodes the operation and queues them for the back part
`timescale 1ns / 1ps
module cau_front
    import cau_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_req,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);
    t_cls w_cls;
    t_cmd w_cmd;

    // operation decoder
    always_comb begin
        w_cls = '0;
        unique case (i_req.operation)
            OP_ADD:  w_cls.add  = 1'b1;
            OP_MUL:  w_cls.mul  = 1'b1;
            OP_DIV:  w_cls.div  = 1'b1;
            OP_SQ:   w_cls.sq   = 1'b1;
            OP_BS:   w_cls.bs   = 1'b1;
            OP_CUBE: w_cls.cube = 1'b1;
            default: w_cls      = '0;
        endcase
    end

    // zero divisor check and packing
    always_comb begin
        w_cmd.cls  = w_cls;
        w_cmd.dz   = w_cls.div && (i_req.b_re == '0) && (i_req.b_im == '0);
        w_cmd.a_re = i_req.a_re;
        w_cmd.a_im = i_req.a_im;
        w_cmd.b_re = i_req.b_re;
        w_cmd.b_im = i_req.b_im;
    end

    // decoupling queue toward the back part
    cau_queue #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (4)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (w_cmd),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_data  (o_cmd),
        .o_empty (o_empty)
    );

endmodule

// File: hdl/cau_div.sv
// restoring divider pipeline, one dividend bit per stage, two quotients sharing the divisor
`timescale 1ns / 1ps
module cau_div
    import cau_pkg::*;
#(
    parameter int FRAC_BITS = 28
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_dv  i_stg,
    output t_dv  o_stg
);
    localparam int DW = 64 + FRAC_BITS;

    t_dv r_stg [1:DW];

    // one restoring step: {quotient bit, new remainder}
    function automatic logic [64:0] f_step(input logic [63:0] rem, input logic dbit,
                                           input logic [63:0] den);
        logic [64:0] t;
        logic [64:0] d;
        logic [64:0] res;
        t = {rem, dbit};
        d = {1'b0, den};
        if (t >= d) begin
            res = {1'b1, 64'(t - d)};
        end else begin
            res = {1'b0, t[63:0]};
        end
        return res;
    endfunction

    genvar k;
    generate
        for (k = 0; k < DW; k++) begin : g_stage
            localparam int BIT = DW - 1 - k;
            t_dv         s_cur;
            t_dv         n_stg;
            logic        d_re, d_im;
            logic [64:0] s_re, s_im;

            if (k == 0) begin : g_first
                assign s_cur = i_stg;
            end else begin : g_next
                assign s_cur = r_stg[k];
            end

            // dividend is the magnitude shifted up by the fraction width
            if (BIT >= FRAC_BITS) begin : g_bit
                assign d_re = s_cur.mag_re[BIT-FRAC_BITS];
                assign d_im = s_cur.mag_im[BIT-FRAC_BITS];
            end else begin : g_zero
                assign d_re = 1'b0;
                assign d_im = 1'b0;
            end

            assign s_re = f_step(s_cur.rem_re, d_re, s_cur.den);
            assign s_im = f_step(s_cur.rem_im, d_im, s_cur.den);

            // shift in the quotient bit, sticky flag on bits falling out
            always_comb begin
                n_stg        = s_cur;
                n_stg.rem_re = s_re[63:0];
                n_stg.rem_im = s_im[63:0];
                n_stg.q_re   = {s_cur.q_re[32:0], s_re[64]};
                n_stg.q_im   = {s_cur.q_im[32:0], s_im[64]};
                n_stg.st_re  = s_cur.st_re | s_cur.q_re[33];
                n_stg.st_im  = s_cur.st_im | s_cur.q_im[33];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_stg[k+1].side.valid <= 1'b0;
                end else if (i_en) begin
                    r_stg[k+1] <= n_stg;
                end
            end
        end
    endgenerate

    assign o_stg = r_stg[DW];

endmodule

// File: hdl/cau_back.sv
// back part: multiplier stages, cube stage, divider and result queue
`timescale 1ns / 1ps
module cau_back
    import cau_pkg::*;
#(
    parameter int FRAC_BITS = 28
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  logic i_empty,
    output logic o_pop,
    output t_res o_res,
    output logic o_empty,
    input  logic i_pop
);
    typedef struct packed {
        logic               valid;
        t_cls               cls;
        logic               dz;
        logic signed [31:0] ar;
        logic signed [31:0] ai;
        logic signed [32:0] sum_re;
        logic signed [32:0] sum_im;
        logic signed [63:0] p_arbr;
        logic signed [63:0] p_aibi;
        logic signed [63:0] p_arbi;
        logic signed [63:0] p_aibr;
        logic signed [63:0] p_arar;
        logic signed [63:0] p_aiai;
        logic signed [63:0] p_arai;
        logic signed [63:0] p_brbr;
        logic signed [63:0] p_bibi;
    } t_sa;

    typedef struct packed {
        logic               valid;
        logic               cube;
        logic               div;
        logic               dz;
        logic signed [31:0] ar;
        logic signed [31:0] ai;
        logic signed [31:0] sr;
        logic signed [31:0] si;
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic               ov;
        logic [30:0]        m;
        logic [63:0]        den;
        logic [63:0]        mag_re;
        logic [63:0]        mag_im;
        logic               neg_re;
        logic               neg_im;
    } t_sb;

    typedef struct packed {
        t_sb                b;
        logic signed [63:0] c_arsr;
        logic signed [63:0] c_arsi;
        logic signed [63:0] c_aisr;
        logic signed [63:0] c_aisi;
    } t_sc;

    typedef struct packed {
        logic valid;
        t_res res;
    } t_se;

    localparam logic signed [64:0] MOD_MAX = 65'sd2147483647;

    logic w_adv, w_ofull;
    t_sa  r_a, n_a;
    t_sb  r_b, n_b;
    t_sc  r_c, n_c;
    t_dv  r_d, n_d;
    t_se  r_e, n_e;
    t_dv  w_dout;

    // whole pipeline moves when the result queue has room
    assign w_adv = !w_ofull;
    assign o_pop = w_adv && !i_empty;

    // stage a: operand products
    always_comb begin
        n_a.valid  = !i_empty;
        n_a.cls    = i_cmd.cls;
        n_a.dz     = i_cmd.dz;
        n_a.ar     = i_cmd.a_re;
        n_a.ai     = i_cmd.a_im;
        n_a.sum_re = 33'(i_cmd.a_re) + 33'(i_cmd.b_re);
        n_a.sum_im = 33'(i_cmd.a_im) + 33'(i_cmd.b_im);
        n_a.p_arbr = i_cmd.a_re * i_cmd.b_re;
        n_a.p_aibi = i_cmd.a_im * i_cmd.b_im;
        n_a.p_arbi = i_cmd.a_re * i_cmd.b_im;
        n_a.p_aibr = i_cmd.a_im * i_cmd.b_re;
        n_a.p_arar = i_cmd.a_re * i_cmd.a_re;
        n_a.p_aiai = i_cmd.a_im * i_cmd.a_im;
        n_a.p_arai = i_cmd.a_re * i_cmd.a_im;
        n_a.p_brbr = i_cmd.b_re * i_cmd.b_re;
        n_a.p_bibi = i_cmd.b_im * i_cmd.b_im;
    end

    // stage b: truncation, sums, saturation, divide operands
    always_comb begin
        logic signed [63:0] fl_arbr, fl_aibi, fl_arbi, fl_aibr, fl_arar, fl_aiai;
        logic signed [63:0] p_abs;
        logic signed [67:0] v_re, v_im;
        logic [32:0]        s_re, s_im, s_sr, s_si;
        logic signed [64:0] msum, n1, n2;
        fl_arbr = r_a.p_arbr >>> FRAC_BITS;
        fl_aibi = r_a.p_aibi >>> FRAC_BITS;
        fl_arbi = r_a.p_arbi >>> FRAC_BITS;
        fl_aibr = r_a.p_aibr >>> FRAC_BITS;
        fl_arar = r_a.p_arar >>> FRAC_BITS;
        fl_aiai = r_a.p_aiai >>> FRAC_BITS;
        p_abs   = (r_a.p_arai < 0) ? -r_a.p_arai : r_a.p_arai;
        v_re    = '0;
        v_im    = '0;
        if (r_a.cls.add) begin
            v_re = 68'(r_a.sum_re);
            v_im = 68'(r_a.sum_im);
        end else if (r_a.cls.mul) begin
            v_re = 68'(fl_arbr) - 68'(fl_aibi);
            v_im = 68'(fl_arbi) + 68'(fl_aibr);
        end else if (r_a.cls.sq) begin
            v_re = 68'(fl_arar) - 68'(fl_aiai);
            v_im = 68'(r_a.p_arai >>> (FRAC_BITS - 1));
        end else if (r_a.cls.bs) begin
            v_re = 68'(fl_arar) - 68'(fl_aiai);
            v_im = 68'(p_abs >>> (FRAC_BITS - 1));
        end
        s_re = f_sat(v_re);
        s_im = f_sat(v_im);
        s_sr = f_sat(68'(fl_arar));
        s_si = f_sat(68'(fl_aiai));
        msum = 65'(fl_arar) + 65'(fl_aiai);
        n1   = 65'(r_a.p_arbr) + 65'(r_a.p_aibi);
        n2   = 65'(r_a.p_aibr) - 65'(r_a.p_arbi);

        n_b.valid  = r_a.valid;
        n_b.cube   = r_a.cls.cube;
        n_b.div    = r_a.cls.div && !r_a.dz;
        n_b.dz     = r_a.dz;
        n_b.ar     = r_a.ar;
        n_b.ai     = r_a.ai;
        n_b.sr     = s_sr[31:0];
        n_b.si     = s_si[31:0];
        n_b.re     = s_re[31:0];
        n_b.im     = s_im[31:0];
        n_b.ov     = r_a.cls.cube ? (s_sr[32] | s_si[32]) : (s_re[32] | s_im[32]);
        n_b.m      = (msum > MOD_MAX) ? WORD_MAX[30:0] : msum[30:0];
        n_b.den    = $unsigned(r_a.p_brbr) + $unsigned(r_a.p_bibi);
        n_b.neg_re = n1[64];
        n_b.neg_im = n2[64];
        n_b.mag_re = n1[64] ? 64'(-n1) : n1[63:0];
        n_b.mag_im = n2[64] ? 64'(-n2) : n2[63:0];
    end

    // stage c: cube products from the saturated squares
    always_comb begin
        n_c.b      = r_b;
        n_c.c_arsr = r_b.ar * r_b.sr;
        n_c.c_arsi = r_b.ar * r_b.si;
        n_c.c_aisr = r_b.ai * r_b.sr;
        n_c.c_aisi = r_b.ai * r_b.si;
    end

    // stage d: cube result and divider entry
    always_comb begin
        logic signed [67:0] t_arsi, t_aisr, v_re, v_im;
        logic [32:0]        s_re, s_im;
        t_arsi = 68'(r_c.c_arsi >>> FRAC_BITS);
        t_aisr = 68'(r_c.c_aisr >>> FRAC_BITS);
        v_re   = 68'(r_c.c_arsr >>> FRAC_BITS) - ((t_arsi <<< 1) + t_arsi);
        v_im   = ((t_aisr <<< 1) + t_aisr) - 68'(r_c.c_aisi >>> FRAC_BITS);
        s_re   = f_sat(v_re);
        s_im   = f_sat(v_im);

        n_d            = '0;
        n_d.side.valid = r_c.b.valid;
        n_d.side.m     = r_c.b.m;
        n_d.side.dz    = r_c.b.dz;
        n_d.side.div   = r_c.b.div;
        if (r_c.b.cube) begin
            n_d.side.re = s_re[31:0];
            n_d.side.im = s_im[31:0];
            n_d.side.ov = r_c.b.ov | s_re[32] | s_im[32];
        end else begin
            n_d.side.re = r_c.b.re;
            n_d.side.im = r_c.b.im;
            n_d.side.ov = r_c.b.ov;
        end
        n_d.den    = r_c.b.den;
        n_d.mag_re = r_c.b.mag_re;
        n_d.mag_im = r_c.b.mag_im;
        n_d.neg_re = r_c.b.neg_re;
        n_d.neg_im = r_c.b.neg_im;
    end

    // stage registers a to d
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid      <= 1'b0;
            r_b.valid      <= 1'b0;
            r_c.b.valid    <= 1'b0;
            r_d.side.valid <= 1'b0;
        end else if (w_adv) begin
            r_a <= n_a;
            r_b <= n_b;
            r_c <= n_c;
            r_d <= n_d;
        end
    end

    // divider pipeline
    cau_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_stg   (r_d),
        .o_stg   (w_dout)
    );

    // floored signed quotient with saturation, msb flags saturation
    function automatic logic [32:0] f_qres(input logic [33:0] q, input logic st,
                                           input logic neg, input logic rnz);
        logic [32:0] res;
        logic [33:0] nq;
        nq = 34'd0 - q - 34'(rnz);
        if (!neg) begin
            if (st || (q > 34'(WORD_MAX))) begin
                res = {1'b1, WORD_MAX};
            end else begin
                res = {1'b0, q[31:0]};
            end
        end else begin
            if (st || (q > 34'(WORD_MIN)) || ((q == 34'(WORD_MIN)) && rnz)) begin
                res = {1'b1, WORD_MIN};
            end else begin
                res = {1'b0, nq[31:0]};
            end
        end
        return res;
    endfunction

    // stage e: pick divide or carried result
    always_comb begin
        logic [32:0] s_re, s_im;
        s_re = f_qres(w_dout.q_re, w_dout.st_re, w_dout.neg_re, w_dout.rem_re != '0);
        s_im = f_qres(w_dout.q_im, w_dout.st_im, w_dout.neg_im, w_dout.rem_im != '0);
        n_e.valid          = w_dout.side.valid;
        n_e.res.modulus_sq = w_dout.side.m;
        n_e.res.div_zero   = w_dout.side.dz;
        if (w_dout.side.div) begin
            n_e.res.res_re   = s_re[31:0];
            n_e.res.res_im   = s_im[31:0];
            n_e.res.overflow = s_re[32] | s_im[32];
        end else begin
            n_e.res.res_re   = w_dout.side.re;
            n_e.res.res_im   = w_dout.side.im;
            n_e.res.overflow = w_dout.side.ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e.valid <= 1'b0;
        end else if (w_adv) begin
            r_e <= n_e;
        end
    end

    // result queue
    cau_queue #(
        .WIDTH ($bits(t_res)),
        .DEPTH (2)
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_e.valid),
        .i_data  (r_e.res),
        .o_full  (w_ofull),
        .i_pop   (i_pop),
        .o_data  (o_res),
        .o_empty (o_empty)
    );

endmodule

// File: tb/cau_checker.sv
// result predictor and scoreboard for the complex arithmetic unit
`timescale 1ns / 1ps
module cau_checker
    import cau_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  logic   i_full,
    input  t_req   i_req,
    input  logic   i_pop,
    input  logic   i_empty,
    input  t_res   i_res,
    output int     o_errors,
    output int     o_pending
);

    localparam int FB = 28;
    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;

    t_res expected_q[$];

    // floor of v / 2^n
    function automatic longint floor_shr(input longint v, input int n);
        return v >>> n;
    endfunction

    function automatic longint fx_mul(input longint x, input longint y);
        return floor_shr(x * y, FB);
    endfunction

    function automatic longint clamp_word(input longint v, inout bit ov);
        if (v > WMAX) begin
            ov = 1;
            return WMAX;
        end
        if (v < WMIN) begin
            ov = 1;
            return WMIN;
        end
        return v;
    endfunction

    // floored quotient of (p1+p2) * 2^FB / den with a 34-bit magnitude cap
    function automatic longint fx_div(input longint p1, input longint p2,
                                      input logic [63:0] den, inout bit ov);
        logic [63:0] cap;
        logic [63:0] sum;
        logic [63:0] mag;
        logic [63:0] q;
        logic [63:0] r;
        bit          neg;
        cap = 64'd1 << 33;
        neg = p1 < -p2;
        sum = p1 + p2;
        mag = neg ? -sum : sum;
        q = mag / den;
        r = mag % den;
        if (q > cap) q = cap;
        for (int i = 0; i < FB; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q[0] = 1'b1;
            end
            if (q > cap) q = cap;
        end
        if (!neg) return clamp_word(longint'(q), ov);
        return clamp_word(-longint'(q) - (r != 0 ? 1 : 0), ov);
    endfunction

    function automatic t_res predict_result(input t_req rq);
        t_res        rs;
        longint      ar, ai, br, bi, re, im, m, p, sr, si;
        logic [63:0] den;
        bit          ov;
        ar = rq.a_re;
        ai = rq.a_im;
        br = rq.b_re;
        bi = rq.b_im;
        re = 0;
        im = 0;
        ov = 0;
        rs = '0;
        case (rq.operation)
            OP_ADD: begin
                re = clamp_word(ar + br, ov);
                im = clamp_word(ai + bi, ov);
            end
            OP_MUL: begin
                re = clamp_word(fx_mul(ar, br) - fx_mul(ai, bi), ov);
                im = clamp_word(fx_mul(ar, bi) + fx_mul(ai, br), ov);
            end
            OP_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    rs.div_zero = 1'b1;
                end else begin
                    re = fx_div(ar * br, ai * bi, den, ov);
                    im = fx_div(ai * br, -(ar * bi), den, ov);
                end
            end
            OP_SQ, OP_BS: begin
                p = ar * ai;
                re = clamp_word(fx_mul(ar, ar) - fx_mul(ai, ai), ov);
                if (rq.operation == OP_BS && p < 0) p = -p;
                im = clamp_word(floor_shr(p, FB - 1), ov);
            end
            OP_CUBE: begin
                sr = clamp_word(fx_mul(ar, ar), ov);
                si = clamp_word(fx_mul(ai, ai), ov);
                re = clamp_word(fx_mul(ar, sr) - 3 * fx_mul(ar, si), ov);
                im = clamp_word(3 * fx_mul(ai, sr) - fx_mul(ai, si), ov);
            end
            default: begin
            end
        endcase
        m = fx_mul(ar, ar) + fx_mul(ai, ai);
        if (m > WMAX) m = WMAX;
        rs.res_re = re[31:0];
        rs.res_im = im[31:0];
        rs.modulus_sq = m[30:0];
        rs.overflow = ov;
        return rs;
    endfunction

    // predict on accepted requests, compare on accepted results
    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            expected_q.delete();
            o_errors <= 0;
        end else begin
            if (i_push && !i_full) expected_q.push_back(predict_result(i_req));
            if (i_pop && !i_empty) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, i_res);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (want !== i_res) begin
                        $display("%0t: mismatch re exp %h got %h, im exp %h got %h",
                                 $time, want.res_re, i_res.res_re,
                                 want.res_im, i_res.res_im);
                        $display("%0t:   mod exp %h got %h, ov exp %b got %b, dz exp %b got %b",
                                 $time, want.modulus_sq, i_res.modulus_sq, want.overflow,
                                 i_res.overflow, want.div_zero, i_res.div_zero);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
        o_pending = expected_q.size();
    end

endmodule

// File: tb/tb_top.sv
// stimulus and verdict for the complex arithmetic unit testbench
`timescale 1ns / 1ps
module tb_top;
    import cau_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_push = 1'b0;
    logic i_pop = 1'b0;
    t_req i_req = '0;
    logic o_full;
    logic o_empty;
    t_res o_res;
    int   errors;
    int   pending;
    bit   pop_en = 1'b1;

    localparam logic [31:0] Q_ONE = 32'h1000_0000;

    complex_arith_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (i_push),
        .i_req  (i_req),
        .o_full (o_full),
        .o_empty(o_empty),
        .i_pop  (i_pop),
        .o_res  (o_res)
    );

    cau_checker u_checker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .i_full   (o_full),
        .i_req    (i_req),
        .i_pop    (i_pop),
        .i_empty  (o_empty),
        .i_res    (o_res),
        .o_errors (errors),
        .o_pending(pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // operand word: edges, small fractions or full random
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return $urandom_range(0, 1) ? Q_ONE : -Q_ONE;
            4, 5: return $urandom();
            default: return {{5{$urandom_range(0, 1) == 1}}, 27'($urandom())};
        endcase
    endfunction

    task automatic send_req(input logic [2:0] op, input logic [31:0] ar,
                            input logic [31:0] ai, input logic [31:0] br,
                            input logic [31:0] bi);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_push <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_req <= '{op, ar, ai, br, bi};
        i_push <= 1'b1;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
    endtask

    // result side: random stalls with quiet stretches
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else if (pop_en) begin
            i_pop <= ($urandom_range(0, 99) < 70) ? 1'b1 : 1'b0;
        end else begin
            i_pop <= 1'b1;
        end
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        logic [2:0] op;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: each operation, word extremes, zero divisor, unused codes
        send_req(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF);
        send_req(OP_ADD, 32'h1234_5678, 32'h0, 32'hF000_0000, 32'h0);
        send_req(OP_MUL, Q_ONE, Q_ONE, Q_ONE, -Q_ONE);
        send_req(OP_MUL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_req(OP_MUL, 32'hFFFF_FFFF, 32'h1, 32'h1, 32'hFFFF_FFFF);
        send_req(OP_DIV, Q_ONE, Q_ONE, 32'h0, 32'h0);
        send_req(OP_DIV, Q_ONE, 32'h0, 32'h3000_0000, 32'h0);
        send_req(OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h0);
        send_req(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_req(OP_DIV, 32'hFFFF_FFFF, 32'h1, 32'h0, 32'h1);
        send_req(OP_SQ, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0);
        send_req(OP_SQ, -Q_ONE, Q_ONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_req(OP_BS, -Q_ONE, Q_ONE, 32'h0, 32'h0);
        send_req(OP_BS, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0);
        send_req(OP_CUBE, 32'h1800_0000, 32'hE800_0000, 32'h0, 32'h0);
        send_req(OP_CUBE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0);
        send_req(3'd6, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1, 32'h1);
        send_req(3'd7, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0);
        // hold off until everything has drained
        i_push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        // random phase, with a stall-free stretch in the middle
        for (int n = 0; n < 1700; n++) begin
            if (n == 800) pop_en = 1'b0;
            if (n == 1000) pop_en = 1'b1;
            op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                             : 3'($urandom_range(0, 5));
            if (op == OP_DIV && $urandom_range(0, 15) == 0) begin
                send_req(op, rand_word(), rand_word(), 32'h0, 32'h0);
            end else begin
                send_req(op, rand_word(), rand_word(), rand_word(), rand_word());
            end
        end
        i_push <= 1'b0;
        pop_en = 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && o_empty) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
